@@ rtl/rtcsu_pkg.sv @@
// Shared types and constants for the RTC snapshot to Unix time converter.
`default_nettype none
package rtcsu_pkg;

    // Configuration register indexes (paddr[3:2])
    localparam logic [1:0] REG_CENTURY_EN = 2'd0;
    localparam logic [1:0] REG_BASE_YEAR  = 2'd1;
    localparam logic [1:0] REG_TZ_OFFSET  = 2'd2;

    localparam logic [13:0] BASE_YEAR_RST = 14'd2021;
    localparam logic [4:0]  TZ_OFFSET_RST = 5'd2;

    // Date arithmetic constants
    localparam logic [31:0] EPOCH_DAYS  = 32'd719561;
    localparam logic [31:0] DAY_SECONDS = 32'd86400;

    // Reciprocal multipliers: x/100 and x/5 for the value ranges in use
    localparam logic [12:0] CY_DIV100_MUL  = 13'd5243;   // 14-bit x, >> 19
    localparam logic [15:0] Y_DIV100_MUL   = 16'd41944;  // 16-bit x, >> 22
    localparam logic [7:0]  M_DIV5_MUL     = 8'd205;     // 10-bit x, >> 10

    // Terms for year = 2^32 - 1 (year 0 before March, wrapped)
    localparam logic [31:0] WRAP_T365 = 32'hFFFF_FE93;
    localparam logic [31:0] WRAP_Y4   = 32'h3FFF_FFFF;
    localparam logic [31:0] WRAP_Y100 = 32'd42949672;
    localparam logic [31:0] WRAP_Y400 = 32'd10737418;

    typedef struct packed {
        logic        century_enabled;
        logic [13:0] base_year;
        logic [4:0]  zone_hours;
    } cfg_t;

    typedef struct packed {
        logic [7:0] second;
        logic [7:0] minute;
        logic [7:0] hour;
        logic [7:0] day;
        logic [7:0] month;
        logic [7:0] year;
        logic [7:0] century;
        logic       binary_mode;
        logic       hour_24_mode;
    } snap_item_t;

    typedef struct packed {
        logic [31:0] unix_seconds;
        logic [15:0] full_year;
        logic [7:0]  month_out;
        logic [7:0]  day_out;
        logic [7:0]  hour_out;
        logic [7:0]  minute_out;
        logic [7:0]  second_out;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_DIV,
        ST_DAYS,
        ST_SCALE,
        ST_EMIT
    } back_state_t;

    localparam int QDEPTH = 2;

endpackage
`default_nettype wire

@@ rtl/rtc_snapshot_to_unix_time.sv @@
// Top level: RTC snapshot to Unix time converter with APB configuration.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_ready    | update_in_progress, raw_* bytes, mode bits
//  out     | out_valid / out_ready  | unix_seconds, full_year, *_out fields
//  cfg     | psel/penable/pwrite    | paddr[3:2] register index, pwdata
//
// The front end takes one snapshot a cycle while the two-entry queue has room;
// snapshots that give no result (updating, or not matching the kept one) are
// consumed without a push. A matched pair is converted by the back-end sequencer
// in the steps decode, year, divide, days, scale and emit, one item at a time.
// Reset restores the configuration defaults and clears the kept snapshot;
// there is no clearing pass. A stalled output holds the sequencer in its emit
// step, the queue then fills and in_ready drops.
`default_nettype none
module rtc_snapshot_to_unix_time (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    // input channel
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        update_in_progress,
    input  wire logic [7:0]  raw_second,
    input  wire logic [7:0]  raw_minute,
    input  wire logic [7:0]  raw_hour,
    input  wire logic [7:0]  raw_day,
    input  wire logic [7:0]  raw_month,
    input  wire logic [7:0]  raw_year,
    input  wire logic [7:0]  raw_century,
    input  wire logic        binary_mode,
    input  wire logic        hour_24_mode,
    // output channel
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      unix_seconds,
    output logic [15:0]      full_year,
    output logic [7:0]       month_out,
    output logic [7:0]       day_out,
    output logic signed [7:0] hour_out,
    output logic [7:0]       minute_out,
    output logic [7:0]       second_out
);
    import rtcsu_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       cfg_write;
    snap_item_t in_item;
    snap_item_t q_push_item;
    snap_item_t q_head;
    logic       q_push;
    logic       q_pop;
    logic       q_full;
    logic       q_not_empty;
    result_t    result;

    // APB: no wait states, write lands in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[3:2])
                REG_CENTURY_EN: cfg_next.century_enabled = pwdata[0];
                REG_BASE_YEAR:  cfg_next.base_year       = pwdata[13:0];
                REG_TZ_OFFSET:  cfg_next.zone_hours      = pwdata[4:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_CENTURY_EN: prdata = {31'd0, cfg_reg.century_enabled};
            REG_BASE_YEAR:  prdata = {18'd0, cfg_reg.base_year};
            REG_TZ_OFFSET:  prdata = {27'd0, cfg_reg.zone_hours};
            default:        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.century_enabled <= 1'b0;
            cfg_reg.base_year       <= BASE_YEAR_RST;
            cfg_reg.zone_hours      <= TZ_OFFSET_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Pack the snapshot fields for the front end
    assign in_item = '{second:       raw_second,
                       minute:       raw_minute,
                       hour:         raw_hour,
                       day:          raw_day,
                       month:        raw_month,
                       year:         raw_year,
                       century:      raw_century,
                       binary_mode:  binary_mode,
                       hour_24_mode: hour_24_mode};

    rtcsu_front u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .century_enabled    (cfg_reg.century_enabled),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .update_in_progress (update_in_progress),
        .in_item            (in_item),
        .q_full             (q_full),
        .q_push             (q_push),
        .q_item             (q_push_item)
    );

    rtcsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    rtcsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_item    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    // Unpack the result register onto the output ports
    assign unix_seconds = result.unix_seconds;
    assign full_year    = result.full_year;
    assign month_out    = result.month_out;
    assign day_out      = result.day_out;
    assign hour_out     = result.hour_out;
    assign minute_out   = result.minute_out;
    assign second_out   = result.second_out;

endmodule
`default_nettype wire

@@ rtl/rtcsu_front.sv @@
// Front end: accepts snapshots, drops unstable ones, queues matched pairs.
`default_nettype none
module rtcsu_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 century_enabled,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 update_in_progress,
    input  wire rtcsu_pkg::snap_item_t in_item,
    input  wire logic                 q_full,
    output logic                      q_push,
    output rtcsu_pkg::snap_item_t     q_item
);
    import rtcsu_pkg::*;

    logic [55:0] last_reg;
    logic [55:0] last_next;
    logic        have_last_reg;
    logic        have_last_next;
    logic [55:0] snap_bytes;
    logic        accept;
    logic        match;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Century byte is held at zero when unused so it never breaks a match
    assign snap_bytes = {in_item.second, in_item.minute, in_item.hour, in_item.day,
                         in_item.month, in_item.year,
                         (century_enabled ? in_item.century : 8'd0)};
    assign match = have_last_reg && (snap_bytes == last_reg);

    always_comb
    begin
        q_item         = in_item;
        q_item.century = snap_bytes[7:0];
        q_push         = 1'b0;
        last_next      = last_reg;
        have_last_next = have_last_reg;
        if (accept && !update_in_progress)
        begin
            if (match)
            begin
                q_push         = 1'b1;
                have_last_next = 1'b0;
            end
            else
            begin
                last_next      = snap_bytes;
                have_last_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            have_last_reg <= 1'b0;
        end
        else
        begin
            last_reg      <= last_next;
            have_last_reg <= have_last_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rtcsu_queue.sv @@
// Two-entry queue between the front end and the timestamp sequencer.
`default_nettype none
module rtcsu_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire rtcsu_pkg::snap_item_t push_item,
    input  wire logic                  pop,
    output logic                       full,
    output logic                       not_empty,
    output rtcsu_pkg::snap_item_t      head
);
    import rtcsu_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    snap_item_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0]       wptr_reg;
    logic [PTR_W-1:0]       wptr_next;
    logic [PTR_W-1:0]       rptr_reg;
    logic [PTR_W-1:0]       rptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   do_push;
    logic                   do_pop;

    assign full      = (count_reg == CNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wptr_next = (wptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rptr_next = (rptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

@@ rtl/rtcsu_back.sv @@
// Back end: decodes a matched snapshot and computes the Unix timestamp.
`default_nettype none
module rtcsu_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rtcsu_pkg::cfg_t       cfg,
    input  wire logic                  q_valid,
    input  wire rtcsu_pkg::snap_item_t q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output rtcsu_pkg::result_t         result
);
    import rtcsu_pkg::*;

    function automatic logic [7:0] bcd_byte(input logic [7:0] v);
        return 8'(v[3:0]) + 8'(v[7:4]) * 8'd10;
    endfunction

    function automatic logic [7:0] bcd_hour(input logic [7:0] v);
        logic [7:0] s;
        s = 8'(v[3:0]) + 8'(v[6:4]) * 8'd10;
        return s | {v[7], 7'd0};
    endfunction

    // Input stays below 140, so five conditional subtracts reach the remainder
    function automatic logic [7:0] mod24(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        for (int k = 0; k < 5; k++)
        begin
            if (r >= 8'd24)
            begin
                r = r - 8'd24;
            end
        end
        return r;
    endfunction

    back_state_t state_reg;
    back_state_t state_next;

    logic [7:0]  sec_reg, min_reg, hr_reg, day_reg, mon_reg, yr_reg, cen_reg;
    logic [7:0]  cbase_reg;
    logic [15:0] full_year_reg;
    logic [7:0]  hsum_reg;
    logic [15:0] y_reg;
    logic [7:0]  m_reg;
    logic        wrap_reg;
    logic [9:0]  y100_reg;
    logic [31:0] tod_reg;
    logic [31:0] days_reg;
    logic [31:0] dsec_reg;
    result_t     res_reg;
    logic        out_valid_reg;

    logic        emit_fire;
    logic        bin;
    logic [7:0]  hr_dec;
    logic [7:0]  hr_24;
    logic [26:0] cbase_prod;
    logic [7:0]  cent_sel;
    logic [15:0] yr_sum;
    logic [15:0] yr_full;
    logic        early_month;
    logic [15:0] y_adj;
    logic [31:0] y100_prod;
    logic [31:0] hs32;
    logic [9:0]  m3;
    logic [17:0] frac_prod;
    logic [31:0] t365, ty4, ty100, ty400;

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    // Stage helpers
    assign bin        = q_item.binary_mode;
    assign hr_dec     = bin ? q_item.hour : bcd_hour(q_item.hour);
    assign hr_24      = (!q_item.hour_24_mode && hr_dec[7])
                        ? mod24(8'({1'b0, hr_dec[6:0]}) + 8'd12) : hr_dec;
    assign cbase_prod = 27'(cfg.base_year) * 27'(CY_DIV100_MUL);

    assign cent_sel = cfg.century_enabled ? cen_reg : cbase_reg;
    assign yr_sum   = 16'(yr_reg) + 16'(cent_sel) * 16'd100;
    assign yr_full  = (!cfg.century_enabled && (yr_sum < 16'(cfg.base_year)))
                      ? yr_sum + 16'd100 : yr_sum;

    assign early_month = (mon_reg <= 8'd2);
    assign y_adj       = early_month ? full_year_reg - 16'd1 : full_year_reg;
    assign y100_prod   = 32'(y_adj) * 32'(Y_DIV100_MUL);
    assign hs32        = {{24{hsum_reg[7]}}, hsum_reg};

    assign m3        = (10'(m_reg) + 10'd1) * 10'd3;
    assign frac_prod = 18'(m3) * 18'(M_DIV5_MUL);
    assign t365      = wrap_reg ? WRAP_T365 : 32'(y_reg) * 32'd365;
    assign ty4       = wrap_reg ? WRAP_Y4   : 32'(y_reg[15:2]);
    assign ty100     = wrap_reg ? WRAP_Y100 : 32'(y100_reg);
    assign ty400     = wrap_reg ? WRAP_Y400 : 32'(y100_reg[9:2]);

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        emit_fire  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:  state_next = ST_DIV;
            ST_DIV:   state_next = ST_DAYS;
            ST_DAYS:  state_next = ST_SCALE;
            ST_SCALE: state_next = ST_EMIT;
            ST_EMIT:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    emit_fire  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            sec_reg   <= bin ? q_item.second  : bcd_byte(q_item.second);
            min_reg   <= bin ? q_item.minute  : bcd_byte(q_item.minute);
            hr_reg    <= hr_24;
            day_reg   <= bin ? q_item.day     : bcd_byte(q_item.day);
            mon_reg   <= bin ? q_item.month   : bcd_byte(q_item.month);
            yr_reg    <= bin ? q_item.year    : bcd_byte(q_item.year);
            cen_reg   <= bin ? q_item.century : bcd_byte(q_item.century);
            cbase_reg <= cbase_prod[26:19];
        end
        if (state_reg == ST_YEAR)
        begin
            full_year_reg <= yr_full;
            hsum_reg      <= hr_reg + {{3{cfg.zone_hours[4]}}, cfg.zone_hours};
        end
        if (state_reg == ST_DIV)
        begin
            wrap_reg <= early_month && (full_year_reg == 16'd0);
            y_reg    <= y_adj;
            m_reg    <= early_month ? mon_reg + 8'd12 : mon_reg;
            y100_reg <= y100_prod[31:22];
            tod_reg  <= 32'(hs32 * 32'd3600) + 32'(min_reg) * 32'd60 + 32'(sec_reg);
        end
        if (state_reg == ST_DAYS)
        begin
            days_reg <= t365 + ty4 - ty100 + ty400 + 32'(m_reg) * 32'd30
                        + 32'(frac_prod[17:10]) + 32'(day_reg) - EPOCH_DAYS;
        end
        if (state_reg == ST_SCALE)
        begin
            dsec_reg <= days_reg * DAY_SECONDS;
        end
        if (emit_fire)
        begin
            res_reg.unix_seconds <= dsec_reg + tod_reg;
            res_reg.full_year    <= full_year_reg;
            res_reg.month_out    <= mon_reg;
            res_reg.day_out      <= day_reg;
            res_reg.hour_out     <= hsum_reg;
            res_reg.minute_out   <= min_reg;
            res_reg.second_out   <= sec_reg;
        end
    end

endmodule
`default_nettype wire

@@ test/tb_top.sv @@
// Self-checking testbench for the RTC snapshot to Unix time converter.
`timescale 1ns / 1ps
module tb_top;
    import rtcsu_pkg::*;

    // One input item: the update flag plus the register snapshot and mode bits.
    typedef struct packed {
        logic       updating;
        snap_item_t snap;
    } reading_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        update_in_progress = 1'b0;
    logic [7:0]  raw_second = 8'd0;
    logic [7:0]  raw_minute = 8'd0;
    logic [7:0]  raw_hour = 8'd0;
    logic [7:0]  raw_day = 8'd0;
    logic [7:0]  raw_month = 8'd0;
    logic [7:0]  raw_year = 8'd0;
    logic [7:0]  raw_century = 8'd0;
    logic        binary_mode = 1'b0;
    logic        hour_24_mode = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] unix_seconds;
    logic [15:0] full_year;
    logic [7:0]  month_out;
    logic [7:0]  day_out;
    logic signed [7:0] hour_out;
    logic [7:0]  minute_out;
    logic [7:0]  second_out;

    rtc_snapshot_to_unix_time dut (.*);

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Items waiting to be offered, and converted timestamps waiting to come out.
    reading_t pending_readings[$];
    result_t  stamps_due[$];

    // Testbench copy of the configuration and of the kept snapshot.
    cfg_t        rtc_cfg = '{century_enabled: 1'b0, base_year: BASE_YEAR_RST,
                             zone_hours: TZ_OFFSET_RST};
    logic [55:0] kept_snap = 56'd0;
    logic        have_kept = 1'b0;

    int   fails = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    logic in_fire = 1'b0;

    // Phase settings: century enable, reference year, timezone offset.
    bit ph_century [6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    int ph_year    [6] = '{2021, 0, 9999, 9999, 1970, 0};
    int ph_tz      [6] = '{-12, 14, 0, -12, 5, 14};

    function automatic logic [31:0] bcd_value(input logic [31:0] b);
        return (b & 32'h0F) + ((b >> 4) & 32'h0F) * 32'd10;
    endfunction

    // Track the kept snapshot; on a match, decode it and queue the timestamp.
    task automatic absorb_reading(input reading_t r);
        logic [55:0] snap;
        logic [31:0] sec, mnt, hr, day, mon, yr, cen, cy, off32, hx, y, m, t;
        logic [7:0]  hsum;
        result_t     res;
        if (r.updating)
            return;
        snap = {r.snap.second, r.snap.minute, r.snap.hour, r.snap.day,
                r.snap.month, r.snap.year,
                rtc_cfg.century_enabled ? r.snap.century : 8'h00};
        if (!have_kept || snap != kept_snap)
        begin
            kept_snap = snap;
            have_kept = 1'b1;
            return;
        end
        have_kept = 1'b0;

        sec = 32'(snap[55:48]);
        mnt = 32'(snap[47:40]);
        hr  = 32'(snap[39:32]);
        day = 32'(snap[31:24]);
        mon = 32'(snap[23:16]);
        yr  = 32'(snap[15:8]);
        cen = 32'(snap[7:0]);

        if (!r.snap.binary_mode)
        begin
            sec = bcd_value(sec);
            mnt = bcd_value(mnt);
            // the hour keeps its PM flag, only bits 6..4 are the tens digit
            hr  = ((hr & 32'h0F) + ((hr & 32'h70) >> 4) * 32'd10) | (hr & 32'h80);
            day = bcd_value(day);
            mon = bcd_value(mon);
            yr  = bcd_value(yr);
            cen = bcd_value(cen);
        end

        if (!r.snap.hour_24_mode && hr[7])
            hr = ((hr & 32'h7F) + 32'd12) % 32'd24;

        if (rtc_cfg.century_enabled)
            yr = yr + cen * 32'd100;
        else
        begin
            cy = 32'(rtc_cfg.base_year);
            yr = yr + (cy / 32'd100) * 32'd100;
            if (yr < cy)
                yr = yr + 32'd100;
        end
        yr = yr & 32'hFFFF;

        off32 = {{27{rtc_cfg.zone_hours[4]}}, rtc_cfg.zone_hours};
        hsum  = 8'(hr + off32);
        hx    = {{24{hsum[7]}}, hsum};

        // Days since the epoch with March-based months, all in wrapping 32 bits.
        y = yr;
        m = mon;
        if (m <= 32'd2)
        begin
            m = m + 32'd12;
            y = y - 32'd1;
        end
        t = 32'd365 * y + y / 32'd4 - y / 32'd100 + y / 32'd400;
        t = t + 32'd30 * m + (32'd3 * (m + 32'd1)) / 32'd5 + day;
        t = t - EPOCH_DAYS;
        t = t * DAY_SECONDS;
        t = t + 32'd3600 * hx + 32'd60 * mnt + sec;

        res.unix_seconds = t;
        res.full_year    = yr[15:0];
        res.month_out    = mon[7:0];
        res.day_out      = day[7:0];
        res.hour_out     = hsum;
        res.minute_out   = mnt[7:0];
        res.second_out   = sec[7:0];
        stamps_due.push_back(res);
    endtask

    task automatic compare_field(input string name, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (exp_v !== got_v)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            fails++;
        end
    endtask

    // Monitor: sample both handshakes at the rising edge.
    always @(posedge clk)
    begin
        reading_t seen;
        result_t  want;
        in_fire = rst_n && in_valid && in_ready;
        if (in_fire)
        begin
            seen.updating          = update_in_progress;
            seen.snap.second       = raw_second;
            seen.snap.minute       = raw_minute;
            seen.snap.hour         = raw_hour;
            seen.snap.day          = raw_day;
            seen.snap.month        = raw_month;
            seen.snap.year         = raw_year;
            seen.snap.century      = raw_century;
            seen.snap.binary_mode  = binary_mode;
            seen.snap.hour_24_mode = hour_24_mode;
            absorb_reading(seen);
        end
        if (rst_n && out_valid && out_ready)
        begin
            if (stamps_due.size() == 0)
            begin
                $error("result with no timestamp pending: unix_seconds 0x%0h", unix_seconds);
                fails++;
            end
            else
            begin
                want = stamps_due.pop_front();
                compare_field("unix_seconds", want.unix_seconds, unix_seconds);
                compare_field("full_year", 32'(want.full_year), 32'(full_year));
                compare_field("month_out", 32'(want.month_out), 32'(month_out));
                compare_field("day_out", 32'(want.day_out), 32'(day_out));
                compare_field("hour_out", 32'(want.hour_out), 32'($unsigned(hour_out)));
                compare_field("minute_out", 32'(want.minute_out), 32'(minute_out));
                compare_field("second_out", 32'(want.second_out), 32'(second_out));
            end
        end
    end

    // Driver: change inputs at the falling edge. Hold valid and payload until
    // the item is taken, then offer the next one or leave valid low.
    always @(negedge clk)
    begin
        reading_t nxt;
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (!in_valid || in_fire)
        begin
            if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_readings.pop_front();
                in_valid           <= 1'b1;
                update_in_progress <= nxt.updating;
                raw_second         <= nxt.snap.second;
                raw_minute         <= nxt.snap.minute;
                raw_hour           <= nxt.snap.hour;
                raw_day            <= nxt.snap.day;
                raw_month          <= nxt.snap.month;
                raw_year           <= nxt.snap.year;
                raw_century        <= nxt.snap.century;
                binary_mode        <= nxt.snap.binary_mode;
                hour_24_mode       <= nxt.snap.hour_24_mode;
            end
            else
                in_valid <= 1'b0;
        end
    end

    function automatic reading_t make_reading(input logic upd, input logic [7:0] s,
                                              input logic [7:0] mi, input logic [7:0] h,
                                              input logic [7:0] d, input logic [7:0] mo,
                                              input logic [7:0] yy, input logic [7:0] c,
                                              input logic bin, input logic h24);
        reading_t r;
        r.updating          = upd;
        r.snap.second       = s;
        r.snap.minute       = mi;
        r.snap.hour         = h;
        r.snap.day          = d;
        r.snap.month        = mo;
        r.snap.year         = yy;
        r.snap.century      = c;
        r.snap.binary_mode  = bin;
        r.snap.hour_24_mode = h24;
        return r;
    endfunction

    function automatic logic [7:0] encode_field(input int v, input logic bin);
        return bin ? 8'(v) : 8'(((v / 10) << 4) | (v % 10));
    endfunction

    // Mostly plausible clock contents in the chosen encoding, some raw noise.
    function automatic reading_t random_reading();
        reading_t r;
        logic     bin, h24, pm;
        int       hh;
        bin = 1'($urandom_range(1));
        h24 = 1'($urandom_range(1));
        if ($urandom_range(99) < 30)
            return make_reading(1'b0, 8'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                                bin, h24);
        pm = 1'b0;
        if (h24)
            hh = $urandom_range(23);
        else
        begin
            hh = $urandom_range(1, 12);
            pm = 1'($urandom_range(1));
        end
        r = make_reading(1'b0,
                         encode_field($urandom_range(59), bin),
                         encode_field($urandom_range(59), bin),
                         encode_field(hh, bin) | {pm, 7'd0},
                         encode_field($urandom_range(1, 31), bin),
                         encode_field($urandom_range(1, 12), bin),
                         encode_field($urandom_range(99), bin),
                         8'd0, bin, h24);
        case ($urandom_range(4))
            0: r.snap.century = 8'd0;
            1: r.snap.century = encode_field(19, bin);
            2: r.snap.century = encode_field(20, bin);
            3: r.snap.century = encode_field(21, bin);
            default: r.snap.century = encode_field($urandom_range(99), bin);
        endcase
        return r;
    endfunction

    // Queue random traffic until about 'target' non-updating items are in.
    task automatic queue_random_readings(input int target);
        reading_t a, b, u;
        int       n, k, pick;
        n = 0;
        while (n < target)
        begin
            pick = $urandom_range(99);
            a = random_reading();
            u = random_reading();
            u.updating = 1'b1;
            if (pick < 65)
            begin
                // matching pair, maybe split by a mid-update read
                b = a;
                if ($urandom_range(9) == 0)
                    b.snap.binary_mode = ~b.snap.binary_mode;
                if ($urandom_range(9) == 0)
                    b.snap.hour_24_mode = ~b.snap.hour_24_mode;
                if ($urandom_range(99) < 15)
                    b.snap.century = 8'($urandom);
                pending_readings.push_back(a);
                if ($urandom_range(99) < 20)
                    pending_readings.push_back(u);
                pending_readings.push_back(b);
                n += 2;
            end
            else if (pick < 80)
            begin
                // pair broken by one changed byte
                b = a;
                k = $urandom_range(6);
                b.snap[2 + 8 * k +: 8] = b.snap[2 + 8 * k +: 8] ^ 8'($urandom_range(1, 255));
                pending_readings.push_back(a);
                pending_readings.push_back(b);
                n += 2;
            end
            else if (pick < 90)
            begin
                pending_readings.push_back(a);
                n += 1;
            end
            else
                pending_readings.push_back(u);
        end
    endtask

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic en, input logic [13:0] cy, input logic [4:0] tz);
        apb_write(REG_CENTURY_EN, {31'd0, en});
        apb_write(REG_BASE_YEAR, {18'd0, cy});
        apb_write(REG_TZ_OFFSET, {27'd0, tz});
        rtc_cfg.century_enabled = en;
        rtc_cfg.base_year       = cy;
        rtc_cfg.zone_hours      = tz;
    endtask

    // Wait until every item is taken and every timestamp is out, then let the
    // front end finish any snapshot that produced nothing.
    task automatic drain_and_settle();
        do
            @(negedge clk);
        while (pending_readings.size() != 0 || in_valid || stamps_due.size() != 0);
        repeat (20) @(negedge clk);
    endtask

    // Watchdog: far beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("rtc_snapshot_to_unix_time verification failed");
        $finish;
    end

    initial
    begin
        reading_t a, b;
        // Hold reset, then drop it at a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b0;
        rst_n <= 1'b1;

        // Directed part under the reset configuration.
        send_idle_pct = 32;
        recv_idle_pct = 57;
        a = random_reading();
        a.updating = 1'b1;
        pending_readings.push_back(a);
        // BCD, 24-hour, top of every plausible range
        a = make_reading(1'b0, 8'h59, 8'h59, 8'h23, 8'h31, 8'h12, 8'h99, 8'h20, 1'b0, 1'b1);
        pending_readings.push_back(a);
        pending_readings.push_back(a);
        // BCD 12 PM, with a mid-update read between the two copies
        a = make_reading(1'b0, 8'h00, 8'h30, 8'h92, 8'h01, 8'h01, 8'h70, 8'h19, 1'b0, 1'b0);
        b = random_reading();
        b.updating = 1'b1;
        pending_readings.push_back(a);
        pending_readings.push_back(b);
        pending_readings.push_back(a);
        // mode bits come from the completing item: BCD first, binary second
        a = make_reading(1'b0, 8'd45, 8'd7, 8'h8B, 8'd28, 8'd2, 8'd24, 8'd20, 1'b0, 1'b0);
        pending_readings.push_back(a);
        a.snap.binary_mode = 1'b1;
        pending_readings.push_back(a);
        // all zeros: month zero, year below the reference year
        a = make_reading(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
        pending_readings.push_back(a);
        pending_readings.push_back(a);
        // all ones, binary 24-hour: PM bit stays in the hour
        a = make_reading(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1);
        pending_readings.push_back(a);
        pending_readings.push_back(a);
        // all ones, BCD 12-hour: invalid digits with PM conversion
        a.snap.binary_mode  = 1'b0;
        a.snap.hour_24_mode = 1'b0;
        pending_readings.push_back(a);
        pending_readings.push_back(a);
        // mismatch replaces the kept snapshot
        a = random_reading();
        b = random_reading();
        b.snap.second = ~a.snap.second;
        pending_readings.push_back(a);
        pending_readings.push_back(b);
        pending_readings.push_back(b);
        // four equal snapshots give two results
        a = random_reading();
        repeat (4) pending_readings.push_back(a);
        // century byte differs but is ignored while disabled
        a = make_reading(1'b0, 8'h12, 8'h34, 8'h05, 8'h15, 8'h06, 8'h42, 8'h19, 1'b0, 1'b1);
        pending_readings.push_back(a);
        a.snap.century = 8'h20;
        pending_readings.push_back(a);
        drain_and_settle();

        // Random phases, each under its own configuration and idle pattern.
        for (int p = 0; p < 6; p++)
        begin
            if (p < 2)
            begin
                send_idle_pct = 32;
                recv_idle_pct = 57;
            end
            else if (p < 4)
            begin
                send_idle_pct = 57;
                recv_idle_pct = 32;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_config(ph_century[p], 14'(ph_year[p]), 5'(ph_tz[p]));
            queue_random_readings(220);
            drain_and_settle();
        end

        if (fails == 0)
            $display("rtc_snapshot_to_unix_time verification clean");
        else
            $display("rtc_snapshot_to_unix_time verification failed");
        $finish;
    end

endmodule
